// File: sv/sliding_xy_scope_histogram_macros.svh
// Assertion helpers used by the top-level file of this block.
`ifndef SLIDING_XY_SCOPE_HISTOGRAM_MACROS_SVH
`define SLIDING_XY_SCOPE_HISTOGRAM_MACROS_SVH

// Implication checked on every clock edge once reset is released.
`define SXH_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Implication whose right side is checked at the clock edge after the condition.
`define SXH_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

// File: sv/sxh_pkg.sv
package sxh_pkg;

  localparam int WINDOW_DEF     = 1024;
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  localparam int LEN_W   = 16;
  localparam int CNT_W   = 11;
  localparam int INT_W   = 26;
  localparam int CFG_W   = 7;
  localparam int SQRT_ITERS = 16;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic              operation;
    logic signed [15:0] bass_sample;
    logic signed [15:0] treble_sample;
    logic [5:0]        pixel_x;
    logic [5:0]        pixel_y;
  } in_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] hit_count;
    logic [INT_W-1:0] intensity;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MAP,
    ST_SQRT,
    ST_OLD_RD,
    ST_OLD_WAIT,
    ST_OLD_DEC,
    ST_NEW_RD,
    ST_NEW_WAIT,
    ST_NEW_INC,
    ST_RD_RD,
    ST_RD_WAIT,
    ST_RD_MUL,
    ST_RD_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic map;
    logic sqrt_step;
    logic old_rd;
    logic old_dec;
    logic new_rd;
    logic new_inc;
    logic rd_rd;
    logic rd_mul;
    logic rd_out;
  } cmd_t;

  typedef struct packed {
    logic op_read;
    logic clr_done;
    logic sqrt_done;
    logic full;
  } sts_t;

endpackage

// File: sv/sxh_ctrl.sv
module sxh_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  sxh_pkg::sts_t  sts,
  output sxh_pkg::cmd_t  cmd
);

  sxh_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sxh_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sxh_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = sxh_pkg::ST_MAP;
        end
      end
      sxh_pkg::ST_CLEAR: begin
        if (sts.clr_done) begin
          state_nxt = sxh_pkg::ST_IDLE;
        end
      end
      sxh_pkg::ST_MAP: begin
        state_nxt = sts.op_read ? sxh_pkg::ST_RD_RD : sxh_pkg::ST_SQRT;
      end
      sxh_pkg::ST_SQRT: begin
        if (sts.sqrt_done) begin
          state_nxt = sts.full ? sxh_pkg::ST_OLD_RD : sxh_pkg::ST_NEW_RD;
        end
      end
      sxh_pkg::ST_OLD_RD:   state_nxt = sxh_pkg::ST_OLD_WAIT;
      sxh_pkg::ST_OLD_WAIT: state_nxt = sxh_pkg::ST_OLD_DEC;
      sxh_pkg::ST_OLD_DEC:  state_nxt = sxh_pkg::ST_NEW_RD;
      sxh_pkg::ST_NEW_RD:   state_nxt = sxh_pkg::ST_NEW_WAIT;
      sxh_pkg::ST_NEW_WAIT: state_nxt = sxh_pkg::ST_NEW_INC;
      sxh_pkg::ST_NEW_INC:  state_nxt = sxh_pkg::ST_IDLE;
      sxh_pkg::ST_RD_RD:    state_nxt = sxh_pkg::ST_RD_WAIT;
      sxh_pkg::ST_RD_WAIT:  state_nxt = sxh_pkg::ST_RD_MUL;
      sxh_pkg::ST_RD_MUL:   state_nxt = sxh_pkg::ST_RD_OUT;
      sxh_pkg::ST_RD_OUT:   state_nxt = sxh_pkg::ST_IDLE;
      default:              state_nxt = sxh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state_r)
      sxh_pkg::ST_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      sxh_pkg::ST_CLEAR:   cmd.clr_step = 1'b1;
      sxh_pkg::ST_MAP:     cmd.map = 1'b1;
      sxh_pkg::ST_SQRT:    cmd.sqrt_step = 1'b1;
      sxh_pkg::ST_OLD_RD:  cmd.old_rd = 1'b1;
      sxh_pkg::ST_OLD_DEC: cmd.old_dec = 1'b1;
      sxh_pkg::ST_NEW_RD:  cmd.new_rd = 1'b1;
      sxh_pkg::ST_NEW_INC: cmd.new_inc = 1'b1;
      sxh_pkg::ST_RD_RD:   cmd.rd_rd = 1'b1;
      sxh_pkg::ST_RD_MUL:  cmd.rd_mul = 1'b1;
      sxh_pkg::ST_RD_OUT:  cmd.rd_out = 1'b1;
      default: begin
      end
    endcase
  end

endmodule

// File: sv/sxh_dpath.sv
module sxh_dpath #(
  parameter int WINDOW     = sxh_pkg::WINDOW_DEF,
  parameter int MAX_WIDTH  = sxh_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sxh_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sxh_pkg::cmd_t                 cmd,
  output sxh_pkg::sts_t                 sts,
  input  sxh_pkg::in_word_t             in_word,
  input  logic [sxh_pkg::CFG_W-1:0]     frame_width,
  input  logic [sxh_pkg::CFG_W-1:0]     frame_height,
  output logic                          out_strobe,
  output sxh_pkg::out_word_t            out_word
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int PIXN  = MAX_WIDTH * MAX_HEIGHT;
  localparam int PW    = $clog2(PIXN);
  localparam int WW    = $clog2(WINDOW);
  localparam int FW    = WW + 1;
  localparam int MXW   = $clog2(MAX_WIDTH + 1);
  localparam int MYW   = $clog2(MAX_HEIGHT + 1);
  localparam int SW    = sxh_pkg::LEN_W + WW + 1;
  localparam int EW    = 1 + PW + sxh_pkg::LEN_W;
  localparam int CW    = WW + 1;
  localparam int PRW   = CW + SW;

  // Window store: valid, pixel, length.
  logic [EW-1:0]  win_mem [WINDOW];
  logic [EW-1:0]  win_rd_r;
  logic [CW-1:0]  hit_mem [PIXN];
  logic [CW-1:0]  hit_rd_r;

  logic [WW-1:0]  wpos_r;
  logic [FW-1:0]  fill_r;
  logic [SW-1:0]  sum_r;
  logic [PW:0]    clr_r;

  sxh_pkg::in_word_t in_r;
  logic           new_ok_r;
  logic [PW-1:0]  new_pix_r;
  logic           rd_ok_r;
  logic [PW-1:0]  rd_pix_r;

  // Square root, one result bit per iteration over sixteen steps.
  logic [31:0]    sq_r;
  logic [33:0]    rem_r;
  logic [16:0]    root_r;
  logic [4:0]     it_r;
  logic [sxh_pkg::LEN_W-1:0] len_r;
  logic [PRW-1:0] prod_r;

  logic [MXW-1:0] w_sat;
  logic [MYW-1:0] h_sat;
  logic [16:0]    offx, offy;
  logic [16+MXW:0] mx;
  logic [16+MYW:0] my;
  logic [MXW-1:0] xc;
  logic [MYW-1:0] yc;
  logic [31:0]    bb, tt;
  logic [33:0]    rem_sh, trial;
  logic [16:0]    root_sh;
  logic [sxh_pkg::LEN_W-1:0] len_fin;
  logic [PW-1:0]  old_pix;
  logic [PW-1:0]  hit_addr;
  logic           hit_rd_en;
  logic           rd_in_range;

  assign w_sat = (frame_width  > MXW'(MAX_WIDTH))  ? MXW'(MAX_WIDTH)  : MXW'(frame_width);
  assign h_sat = (frame_height > MYW'(MAX_HEIGHT)) ? MYW'(MAX_HEIGHT) : MYW'(frame_height);
  assign offx = 17'({in_r.bass_sample[15] ^ 1'b1, in_r.bass_sample[14:0]});
  assign offy = 17'({in_r.treble_sample[15] ^ 1'b1, in_r.treble_sample[14:0]});
  assign mx = (offx * w_sat) + (17 + MXW)'(32768);
  assign my = (offy * h_sat) + (17 + MYW)'(32768);
  assign xc = mx[16+MXW-1:16];
  assign yc = my[16+MYW-1:16];
  assign bb = 32'($signed(in_r.bass_sample) * $signed(in_r.bass_sample));
  assign tt = 32'($signed(in_r.treble_sample) * $signed(in_r.treble_sample));

  assign rem_sh  = {rem_r[31:0], sq_r[31:30]};
  assign trial   = 34'({root_r, 2'b01});
  assign root_sh = {root_r[15:0], 1'b0};
  // Round to nearest: bump when the remainder exceeds the root.
  assign len_fin = (rem_r > 34'(root_r)) ? 16'(root_r + 17'd1) : root_r[15:0];

  assign rd_in_range = (32'(in_r.pixel_x) < MAX_WIDTH) && (32'(in_r.pixel_y) < MAX_HEIGHT);
  assign old_pix = win_rd_r[sxh_pkg::LEN_W +: PW];
  assign hit_addr = cmd.new_rd ? new_pix_r : (cmd.old_rd ? old_pix : rd_pix_r);
  // The fetched count is held through the wait state that follows each read.
  assign hit_rd_en = cmd.old_rd || cmd.new_rd || cmd.rd_rd;

  assign sts.op_read   = in_r.operation == sxh_pkg::OP_READ;
  assign sts.clr_done  = clr_r[PW];
  assign sts.sqrt_done = it_r == 5'(sxh_pkg::SQRT_ITERS);
  assign sts.full      = fill_r == FW'(WINDOW);

  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_word;
    if (cmd.map) begin
      sq_r     <= bb + tt;
      rem_r    <= '0;
      root_r   <= '0;
      it_r     <= '0;
      new_ok_r <= (MXW'(xc) < w_sat) && (MYW'(yc) < h_sat);
      new_pix_r <= PW'(yc) * PW'(MAX_WIDTH) + PW'(xc);
      rd_ok_r  <= rd_in_range;
      rd_pix_r <= PW'(in_r.pixel_y) * PW'(MAX_WIDTH) + PW'(in_r.pixel_x);
    end
    if (cmd.sqrt_step) begin
      if (it_r != 5'(sxh_pkg::SQRT_ITERS)) begin
        sq_r <= {sq_r[29:0], 2'b00};
        it_r <= it_r + 5'd1;
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= root_sh | 17'd1;
        end else begin
          rem_r  <= rem_sh;
          root_r <= root_sh;
        end
      end else begin
        len_r <= len_fin;
      end
    end
    if (cmd.sqrt_step && sts.sqrt_done && sts.full) win_rd_r <= win_mem[wpos_r];
    if (hit_rd_en) hit_rd_r <= hit_mem[hit_addr];
    if (cmd.old_dec && win_rd_r[EW-1] && hit_rd_r != '0) begin
      hit_mem[old_pix] <= hit_rd_r - CW'(1);
    end
    if (cmd.new_inc) begin
      if (new_ok_r) hit_mem[new_pix_r] <= hit_rd_r + CW'(1);
      win_mem[wpos_r] <= {new_ok_r, new_pix_r, len_r};
    end
    if (cmd.rd_mul) prod_r <= PRW'(hit_rd_r) * PRW'(sum_r);
    if (cmd.clr_step && !clr_r[PW]) hit_mem[clr_r[PW-1:0]] <= '0;
    out_word.hit_count <= rd_ok_r ? sxh_pkg::CNT_W'(hit_rd_r) : '0;
    out_word.intensity <= rd_ok_r ? sxh_pkg::INT_W'(prod_r >> WW) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r     <= '0;
      fill_r     <= '0;
      sum_r      <= '0;
      clr_r      <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= cmd.rd_out;
      if (cmd.clr_step && !clr_r[PW]) clr_r <= clr_r + (PW + 1)'(1);
      if (cmd.old_dec) sum_r <= sum_r - SW'(win_rd_r[sxh_pkg::LEN_W-1:0]);
      if (cmd.new_inc) begin
        sum_r  <= sum_r + SW'(len_r);
        wpos_r <= wpos_r + WW'(1);
        if (!sts.full) fill_r <= fill_r + FW'(1);
      end
    end
  end

endmodule

// File: sv/sliding_xy_scope_histogram.sv
// Channel  Ports                               Direction
// input    start, busy, in_word                in  (busy back out)
// result   out_strobe, out_word                out (one-cycle strobe)
// config   cfg_we, cfg_index, cfg_data         in
//
// After a push word is accepted the block stays busy for the map step, 16 square-root
// steps plus one rounding step, then a read, a wait and an update step each for the
// old and the new histogram pixel once the window is full; before it fills, only the
// new pixel is handled. A read word keeps the block busy through the map, read, wait,
// multiply and output steps, and its result strobes as the block returns to idle.
// After reset the histogram is swept clear, one pixel per cycle, while busy stays high.
// The receiver cannot stall: each result word shows for one cycle only.
module sliding_xy_scope_histogram #(
  parameter int WINDOW     = sxh_pkg::WINDOW_DEF,
  parameter int MAX_WIDTH  = sxh_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sxh_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  sxh_pkg::in_word_t           in_word,
  output logic                        out_strobe,
  output sxh_pkg::out_word_t          out_word,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [sxh_pkg::CFG_W-1:0]   cfg_data
);

  `include "sliding_xy_scope_histogram_macros.svh"

  sxh_pkg::cmd_t cmd;
  sxh_pkg::sts_t sts;
  logic [sxh_pkg::CFG_W-1:0] width_r, height_r;

  // Frame size registers, to be written only while the block is idle (not enforced).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sxh_pkg::CFG_W'(64);
      height_r <= sxh_pkg::CFG_W'(64);
    end else if (cfg_we) begin
      if (cfg_index == sxh_pkg::CFG_IDX_WIDTH) width_r <= cfg_data;
      else height_r <= cfg_data;
    end
  end

  sxh_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  sxh_dpath #(
    .WINDOW     (WINDOW),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_word      (in_word),
    .frame_width  (width_r),
    .frame_height (height_r),
    .out_strobe   (out_strobe),
    .out_word     (out_word)
  );

  // The final step of a read is always followed by a result.
  `SXH_ASSERT_NEXT(a_out_after_read, clk, rst_n, cmd.rd_out, out_strobe)
  // A result is only produced after the final step of a read.
  `SXH_ASSERT_IMP(a_no_out_idle, clk, rst_n, out_strobe, $past(cmd.rd_out))
  // An accepted word always makes the block busy next cycle.
  `SXH_ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy)

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sxh_pkg::*;

  localparam int WIN      = WINDOW_DEF;
  localparam int MAXW     = MAX_WIDTH_DEF;
  localparam int MAXH     = MAX_HEIGHT_DEF;
  localparam int SETTLE   = 40;
  localparam int MAX_CYC  = 600000;

  // Kinds of entries in the pending-stimulus queue.
  typedef enum logic [1:0] { ACT_WORD, ACT_CFG, ACT_DRAIN } act_kind_e;

  typedef struct {
    act_kind_e  kind;
    in_word_t   word;
    logic       idx;
    logic [6:0] val;
  } action_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_strobe;
  out_word_t out_word;
  logic      cfg_we = 1'b0;
  logic      cfg_index = CFG_IDX_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  sliding_xy_scope_histogram DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Stimulus waiting to be driven, and read results still to arrive.
  action_t   pending_q[$];
  out_word_t expected_reads[$];

  // Shadow copy of the block's state.
  logic       win_valid [WIN];
  int         win_pixel [WIN];
  int         win_len   [WIN];
  int         hist      [MAXW*MAXH];
  int         wr_pos;
  int         fill;
  longint     len_total;
  int         frame_w;
  int         frame_h;

  int err_cnt;
  int cyc_cnt;
  int quiet_cnt;
  int words_sent;

  task automatic report(input string msg);
    err_cnt++;
    $display("MISMATCH @%0d: %s", cyc_cnt, msg);
  endtask

  // Square root rounded to nearest, by plain search refinement.
  function automatic int round_sqrt(input longint s);
    longint r;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= s)
        r = r + (longint'(1) << b);
    end
    if (s - r * r > r) r++;
    return int'(r);
  endfunction

  function automatic int scope_coord(input int v, input int size);
    return (((v + 32768) * size) + 32768) >>> 16;
  endfunction

  // Applies one accepted word to the shadow state; reads queue a result.
  task automatic apply_word(input in_word_t w);
    int b, t, cw, ch, x, y, len, p;
    out_word_t r;
    if (w.operation == OP_PUSH) begin
      b   = w.bass_sample;
      t   = w.treble_sample;
      cw  = (frame_w > MAXW) ? MAXW : frame_w;
      ch  = (frame_h > MAXH) ? MAXH : frame_h;
      x   = scope_coord(b, cw);
      y   = scope_coord(t, ch);
      len = round_sqrt(longint'(b) * b + longint'(t) * t) & 16'hFFFF;
      if (fill >= WIN) begin
        // Full window: the oldest pair gives back its hit and its length.
        if (win_valid[wr_pos] && hist[win_pixel[wr_pos]] > 0)
          hist[win_pixel[wr_pos]]--;
        len_total -= win_len[wr_pos];
      end else begin
        fill++;
      end
      win_valid[wr_pos] = (x < cw) && (y < ch);
      win_len[wr_pos]   = len;
      if (win_valid[wr_pos]) begin
        p = y * MAXW + x;
        win_pixel[wr_pos] = p;
        hist[p]++;
      end
      len_total += len;
      wr_pos = (wr_pos + 1) % WIN;
    end else begin
      r.hit_count = CNT_W'(hist[w.pixel_y * MAXW + w.pixel_x]);
      r.intensity = INT_W'((longint'(hist[w.pixel_y * MAXW + w.pixel_x]) * len_total) / WIN);
      expected_reads.push_back(r);
    end
  endtask

  // Counts cycles during which the block has sat idle with nothing offered.
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (rst_n && !busy && !start && !cfg_we) quiet_cnt <= quiet_cnt + 1;
    else quiet_cnt <= 0;
  end

  // Driver: offers words from the pending queue with random gaps, and applies
  // configuration writes and drain pauses only once the block has gone quiet.
  always @(posedge clk) begin
    logic nxt_start;
    logic nxt_we;
    logic idle_ok;
    logic gap;
    if (rst_n) begin
      nxt_start = start;
      nxt_we    = 1'b0;
      if (start && !busy) begin
        apply_word(in_word);
        words_sent++;
        nxt_start = 1'b0;
      end
      idle_ok = !busy && !start && !cfg_we && expected_reads.size() == 0 &&
                quiet_cnt >= SETTLE;
      // A stretch in the middle of the run goes without any sender gaps.
      gap = ($urandom_range(99) < 22) && !(words_sent > 700 && words_sent < 900);
      if (!nxt_start && pending_q.size() != 0) begin
        case (pending_q[0].kind)
          ACT_WORD: begin
            if (!gap) begin
              in_word   <= pending_q[0].word;
              nxt_start = 1'b1;
              void'(pending_q.pop_front());
            end
          end
          ACT_CFG: begin
            if (idle_ok) begin
              cfg_index <= pending_q[0].idx;
              cfg_data  <= pending_q[0].val;
              nxt_we    = 1'b1;
              if (pending_q[0].idx == CFG_IDX_WIDTH) frame_w = pending_q[0].val;
              else frame_h = pending_q[0].val;
              void'(pending_q.pop_front());
            end
          end
          default: begin
            if (idle_ok) void'(pending_q.pop_front());
          end
        endcase
      end
      start  <= nxt_start;
      cfg_we <= nxt_we;
    end
  end

  // Monitor: every strobed result word must match the oldest expected read.
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_strobe) begin
      if (expected_reads.size() == 0) begin
        report("result word with no read outstanding");
      end else begin
        e = expected_reads.pop_front();
        if (out_word.hit_count !== e.hit_count)
          report($sformatf("hit_count got %0d want %0d", out_word.hit_count, e.hit_count));
        if (out_word.intensity !== e.intensity)
          report($sformatf("intensity got %0d want %0d", out_word.intensity, e.intensity));
      end
    end
  end

  always @(posedge clk) begin
    if (cyc_cnt >= MAX_CYC) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic add_push(input int b, input int t);
    action_t a;
    a.kind = ACT_WORD;
    a.word.operation     = OP_PUSH;
    a.word.bass_sample   = 16'(b);
    a.word.treble_sample = 16'(t);
    a.word.pixel_x       = 6'($urandom);
    a.word.pixel_y       = 6'($urandom);
    a.idx = CFG_IDX_WIDTH;
    a.val = '0;
    pending_q.push_back(a);
  endtask

  task automatic add_read(input int x, input int y);
    action_t a;
    a.kind = ACT_WORD;
    a.word.operation     = OP_READ;
    a.word.bass_sample   = 16'($urandom);
    a.word.treble_sample = 16'($urandom);
    a.word.pixel_x       = 6'(x);
    a.word.pixel_y       = 6'(y);
    a.idx = CFG_IDX_WIDTH;
    a.val = '0;
    pending_q.push_back(a);
  endtask

  task automatic add_marker(input act_kind_e k, input logic idx, input int v);
    action_t a;
    a.kind = k;
    a.word = '0;
    a.idx  = idx;
    a.val  = 7'(v);
    pending_q.push_back(a);
  endtask

  // Samples lean toward a few clusters so that pixels collect many hits.
  function automatic int pick_sample();
    case ($urandom_range(3))
      0:       return $urandom_range(65535) - 32768;
      1:       return ($urandom_range(1) != 0) ? 32767 : -32768;
      default: return $urandom_range(4) * 8192 - 16384 + $urandom_range(300);
    endcase
  endfunction

  initial begin
    int w_set [6];
    int h_set [6];
    for (int i = 0; i < WIN; i++) begin
      win_valid[i] = 1'b0; win_pixel[i] = 0; win_len[i] = 0;
    end
    foreach (hist[i]) hist[i] = 0;
    wr_pos = 0; fill = 0; len_total = 0;
    frame_w = 64; frame_h = 64;
    err_cnt = 0; cyc_cnt = 0; quiet_cnt = 0; words_sent = 0;

    // Directed part at the reset frame size: sample extremes, the center,
    // corners, and reads inside and at the edges of the frame.
    add_push(-32768, -32768);
    add_push(32767, 32767);
    add_push(0, 0);
    add_push(-32768, 32767);
    add_push(32767, -32768);
    add_push(-512, -512);
    add_push(0, 0);
    add_read(0, 0);
    add_read(32, 32);
    add_read(63, 63);
    add_read(31, 31);
    add_read(0, 63);
    // A frame of zero width drops every pair.
    add_marker(ACT_CFG, CFG_IDX_WIDTH, 0);
    add_push(100, 200);
    add_push(-32768, 0);
    add_read(0, 32);
    // Oversized frames saturate to the maximum.
    add_marker(ACT_CFG, CFG_IDX_WIDTH, 127);
    add_marker(ACT_CFG, CFG_IDX_HEIGHT, 127);
    add_push(0, 0);
    add_push(32000, 32000);
    add_read(32, 32);
    add_read(63, 63);
    // Smallest frame; earlier pairs keep their own pixels.
    add_marker(ACT_CFG, CFG_IDX_WIDTH, 1);
    add_marker(ACT_CFG, CFG_IDX_HEIGHT, 1);
    add_push(-32768, -32768);
    add_push(0, 0);
    add_read(0, 0);
    add_read(32, 32);

    w_set = '{64, 17, 1, 100, 64, 40};
    h_set = '{64, 64, 9, 3, 127, 0};
    for (int ph = 0; ph < 6; ph++) begin
      add_marker(ACT_CFG, CFG_IDX_WIDTH, w_set[ph]);
      add_marker(ACT_CFG, CFG_IDX_HEIGHT, h_set[ph]);
      for (int n = 0; n < 250; n++) begin
        if ($urandom_range(99) < 80) add_push(pick_sample(), pick_sample());
        else if ($urandom_range(3) == 0) add_read($urandom_range(63), $urandom_range(63));
        else add_read($urandom_range((w_set[ph] > 64 ? 64 : (w_set[ph] == 0 ? 1 : w_set[ph])) - 1),
                      $urandom_range((h_set[ph] > 64 ? 64 : (h_set[ph] == 0 ? 1 : h_set[ph])) - 1));
        // Once mid-phase the sender holds off until all reads are back.
        if (ph == 2 && n == 120) add_marker(ACT_DRAIN, CFG_IDX_WIDTH, 0);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all stimulus, all reads, and a quiet tail.
    do @(posedge clk);
    while (pending_q.size() != 0 || expected_reads.size() != 0 || quiet_cnt < SETTLE);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
